[rtl/lzw_pkg.sv]
// Package: shared types, constants and helpers of the LZW byte encoder.
`timescale 1ns / 1ps
package lzw_pkg;

    localparam int DEF_CODE_LIMIT    = 65535;
    localparam int DEF_TABLE_ENTRIES = 131072;
    localparam logic [15:0] FIRST_CODE = 16'd256;
    localparam int EPOCH_W = 8;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_req;

    typedef struct packed {
        logic [15:0] out_code;
        logic [4:0]  code_width;
        logic        last_code;
    } t_out_req;

    // floor(log2(v)) + 1, zero for zero
    function automatic logic [4:0] code_width_of(input logic [15:0] v);
        logic [4:0] w;
        w = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                w = 5'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

[rtl/lzw_fifo.sv]
// Small register FIFO used on the request and result sides.
`timescale 1ns / 1ps
module lzw_fifo #(
    parameter int W     = 9,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [W-1:0]               o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/lzw_core.sv]
// Back end: dictionary probe, insert and code emission over a single-port table.
`timescale 1ns / 1ps
module lzw_core #(
    parameter int CODE_LIMIT    = lzw_pkg::DEF_CODE_LIMIT,
    parameter int TABLE_ENTRIES = lzw_pkg::DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_empty,
    input  lzw_pkg::t_in_req  i_in_req,
    output logic              o_in_pop,
    input  logic              i_out_room,
    output logic              o_out_push,
    output lzw_pkg::t_out_req o_out_req
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int EW    = lzw_pkg::EPOCH_W;
    localparam int ENT_W = EW + 40;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // entry: {tag, prefix, byte, code}; tag zero is never a live epoch
    logic [ENT_W-1:0] r_mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] r_rd;

    logic [2:0]       r_state, n_state;
    logic [EW-1:0]    r_epoch, n_epoch;
    logic [15:0]      r_prefix, n_prefix;
    logic             r_active, n_active;
    logic [15:0]      r_next, n_next;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_byte, n_byte;
    logic             r_eos, n_eos;

    logic             w_we;
    logic [IDX_W-1:0] w_addr;
    logic [ENT_W-1:0] w_wdata;
    logic [2*IDX_W-1:0] w_prod;
    logic [23:0]      w_key;
    logic [16:0]      w_next_inc;
    logic [EW-1:0]    w_tag;
    logic [15:0]      w_eprefix;
    logic [7:0]       w_ebyte;
    logic [15:0]      w_ecode;

    assign w_key  = {r_prefix, i_in_req.data_byte};
    assign w_prod = w_key[IDX_W-1:0] * lzw_pkg::HASH_MULT[IDX_W-1:0];
    assign w_next_inc = {1'b0, r_next} + 17'd1;
    assign {w_tag, w_eprefix, w_ebyte, w_ecode} = r_rd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rd <= r_mem[w_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_epoch  = r_epoch;
        n_prefix = r_prefix;
        n_active = r_active;
        n_next   = r_next;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_byte   = r_byte;
        n_eos    = r_eos;
        w_we     = 1'b0;
        w_addr   = r_slot;
        w_wdata  = '0;
        o_in_pop   = 1'b0;
        o_out_push = 1'b0;
        o_out_req  = '0;
        case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                n_slot = r_slot + 1'b1;
                if (r_slot == '1) begin
                    n_epoch = EW'(1);
                    n_state = S_FIN;
                end
            end
            S_IDLE: begin
                if (!i_in_empty && i_out_room) begin
                    o_in_pop = 1'b1;
                    n_byte   = i_in_req.data_byte;
                    n_eos    = i_in_req.end_of_stream;
                    if (!r_active) begin
                        n_prefix = {8'd0, i_in_req.data_byte};
                        n_active = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        n_slot  = w_prod[IDX_W-1:0];
                        n_cnt   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_tag == r_epoch && w_eprefix == r_prefix && w_ebyte == r_byte) begin
                    n_prefix = w_ecode;
                    n_state  = S_FIN;
                end else if (w_tag == r_epoch && r_cnt != '1) begin
                    n_slot  = r_slot + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_READ;
                end else begin
                    o_out_push = 1'b1;
                    o_out_req  = '{out_code: r_prefix,
                                   code_width: lzw_pkg::code_width_of(r_next),
                                   last_code: 1'b0};
                    w_we    = (w_tag != r_epoch);
                    w_wdata = {r_epoch, r_prefix, r_byte, r_next};
                    n_prefix = {8'd0, r_byte};
                    n_state  = S_FIN;
                    if (w_next_inc >= 17'(CODE_LIMIT)) begin
                        n_next = lzw_pkg::FIRST_CODE;
                        if (r_epoch == '1) begin
                            n_slot  = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end else begin
                        n_next = w_next_inc[15:0];
                    end
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
                if (r_eos) begin
                    o_out_push = 1'b1;
                    o_out_req  = '{out_code: r_prefix,
                                   code_width: lzw_pkg::code_width_of(r_next),
                                   last_code: 1'b1};
                    n_prefix = '0;
                    n_active = 1'b0;
                    n_next   = lzw_pkg::FIRST_CODE;
                    n_eos    = 1'b0;
                    if (r_epoch == '1) begin
                        n_slot  = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_slot  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_epoch  <= EW'(1);
            r_prefix <= '0;
            r_active <= 1'b0;
            r_next   <= lzw_pkg::FIRST_CODE;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_eos    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_epoch  <= n_epoch;
            r_prefix <= n_prefix;
            r_active <= n_active;
            r_next   <= n_next;
            r_slot   <= n_slot;
            r_cnt    <= n_cnt;
            r_eos    <= n_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |-> r_epoch != '0)
        else $error("live epoch is zero");

    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (r_state == S_CMP || r_state == S_FIN))
        else $error("result pushed outside compare or finish");

    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next >= lzw_pkg::FIRST_CODE && {1'b0, r_next} < 17'(CODE_LIMIT))
        else $error("next free code out of range");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_pop |=> (r_state == S_READ || r_state == S_FIN))
        else $error("request taken without starting work");

endmodule

[rtl/lzw_byte_encoder_unit.sv]
// Top level: LZW byte encoder with request queue, dictionary engine and result queue.
`timescale 1ns / 1ps
// After reset the dictionary table is swept once before the first byte is taken.
// A byte that starts a stream makes no table probe; any other byte makes one or
// more hashed probes into the single-port dictionary memory (one read per probe,
// the insert is written in the last probe's compare step).
// Table entries carry an 8-bit epoch mark, so a stream end or code wrap clears the
// dictionary at once; every 255th clear repeats the sweep.
// TABLE_ENTRIES must be a power of two. Bytes queue two deep, results four deep.
module lzw_byte_encoder_unit #(
    parameter int CODE_LIMIT    = lzw_pkg::DEF_CODE_LIMIT,
    parameter int TABLE_ENTRIES = lzw_pkg::DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lzw_pkg::t_in_req  i_data,
    output logic              empty,
    input  logic              pop,
    output lzw_pkg::t_out_req o_result
);
    localparam int IN_DEPTH  = 2;
    localparam int OUT_DEPTH = 4;

    lzw_pkg::t_in_req  w_in_req;
    lzw_pkg::t_out_req w_out_req;
    logic w_in_empty;
    logic w_in_pop;
    logic w_out_push;
    logic w_out_full;
    logic [$clog2(IN_DEPTH):0]  w_in_count;
    logic [$clog2(OUT_DEPTH):0] w_out_count;
    logic w_out_room;

    assign w_out_room = (w_out_count <= ($clog2(OUT_DEPTH)+1)'(OUT_DEPTH - 2)) && !w_out_full;

    lzw_fifo #(.W($bits(lzw_pkg::t_in_req)), .DEPTH(IN_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data),
        .o_full  (full),
        .i_pop   (w_in_pop),
        .o_data  (w_in_req),
        .o_empty (w_in_empty),
        .o_count (w_in_count)
    );

    lzw_core #(.CODE_LIMIT(CODE_LIMIT), .TABLE_ENTRIES(TABLE_ENTRIES)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (w_in_empty || w_in_count == '0),
        .i_in_req   (w_in_req),
        .o_in_pop   (w_in_pop),
        .i_out_room (w_out_room),
        .o_out_push (w_out_push),
        .o_out_req  (w_out_req)
    );

    lzw_fifo #(.W($bits(lzw_pkg::t_out_req)), .DEPTH(OUT_DEPTH)) u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_req),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (w_out_count)
    );

endmodule

[dv/tb_top.sv]
// Testbench for lzw_byte_encoder_unit: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    lzw_pkg::t_in_req  i_data = '0;
    logic              full;
    logic              empty;
    lzw_pkg::t_out_req o_result;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned n_errors = 0;
    int unsigned n_codes = 0;
    int unsigned n_bytes = 0;
    int unsigned n_streams = 0;
    int unsigned max_width_seen = 0;

    // predictor state
    logic [15:0]       cur_prefix;
    logic              prefix_valid;
    logic [15:0]       free_code;
    logic [15:0]       code_dict [logic [23:0]];
    lzw_pkg::t_out_req code_q [$];

    lzw_byte_encoder_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_data   (i_data),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [4:0] bits_needed(input logic [15:0] v);
        logic [4:0] w;
        w = 5'd0;
        while (v != 16'd0) begin
            w++;
            v = v >> 1;
        end
        return w;
    endfunction

    function automatic void restart_stream();
        cur_prefix   = 16'd0;
        prefix_valid = 1'b0;
        free_code    = lzw_pkg::FIRST_CODE;
        code_dict.delete();
    endfunction

    function automatic void predict_codes(input lzw_pkg::t_in_req req);
        lzw_pkg::t_out_req r;
        logic [23:0] key;
        if (!prefix_valid) begin
            cur_prefix   = {8'd0, req.data_byte};
            prefix_valid = 1'b1;
        end else begin
            key = {cur_prefix, req.data_byte};
            if (code_dict.exists(key)) begin
                cur_prefix = code_dict[key];
            end else begin
                r.out_code   = cur_prefix;
                r.code_width = bits_needed(free_code);
                r.last_code  = 1'b0;
                code_q.push_back(r);
                code_dict[key] = free_code;
                free_code  = free_code + 16'd1;
                cur_prefix = {8'd0, req.data_byte};
                if (free_code == 16'hFFFF) begin
                    code_dict.delete();
                    free_code = lzw_pkg::FIRST_CODE;
                end
            end
        end
        if (req.end_of_stream) begin
            r.out_code   = cur_prefix;
            r.code_width = bits_needed(free_code);
            r.last_code  = 1'b1;
            code_q.push_back(r);
            n_streams++;
            restart_stream();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // sends one byte request; returns at the edge that accepted it
    task automatic send_byte(input logic [7:0] b, input logic eos);
        lzw_pkg::t_in_req req;
        req.data_byte     = b;
        req.end_of_stream = eos;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= req;
        do @(posedge i_clk); while (full);
        predict_codes(req);
        n_bytes++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_codes++;
                if (o_result.code_width > max_width_seen) max_width_seen = o_result.code_width;
                if (code_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected code %0d", o_result.out_code));
                end else begin
                    if (o_result.out_code !== code_q[0].out_code)
                        report_mismatch($sformatf("out_code %0d, want %0d",
                            o_result.out_code, code_q[0].out_code));
                    if (o_result.code_width !== code_q[0].code_width)
                        report_mismatch($sformatf("code_width %0d, want %0d",
                            o_result.code_width, code_q[0].code_width));
                    if (o_result.last_code !== code_q[0].last_code)
                        report_mismatch($sformatf("last_code %0b, want %0b",
                            o_result.last_code, code_q[0].last_code));
                    void'(code_q.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (code_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        for (int i = 0; i < 10; i++) send_byte(8'h61, i == 9);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_random_streams(input int unsigned n_items);
        int unsigned len;
        int unsigned alpha;
        logic [7:0]  b;
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(40, 1);
            alpha = ($urandom_range(2) == 0) ? 256 : $urandom_range(4, 2);
            for (int i = 0; i < len && sent < n_items; i++) begin
                b = (alpha == 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1)) ^ 8'hC3;
                send_byte(b, i == len - 1 || sent == n_items - 1);
                sent++;
            end
        end
    endtask

    task automatic test_pause_until_drained();
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        push <= 1'b0;
        wait_drained();
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
    endtask

    initial begin
        restart_stream();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_streams(350);
        send_idle_pct = 51; recv_stall_pct = 0;  test_random_streams(350);
        test_pause_until_drained();
        send_idle_pct = 0;  recv_stall_pct = 51; test_random_streams(350);
        send_idle_pct = 37; recv_stall_pct = 37; test_random_streams(350);
        push <= 1'b0;
        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("sent %0d bytes in %0d streams, checked %0d codes (widest %0d bits)",
            n_bytes, n_streams, n_codes, max_width_seen);
        $display("idle phases: none, sender, receiver, both; one drain pause");
        if (n_errors == 0 && code_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/lzw_pkg.sv
rtl/lzw_fifo.sv
rtl/lzw_core.sv
rtl/lzw_byte_encoder_unit.sv
dv/tb_top.sv
